### design/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg: shared types and constants of the chunked body decoder
// Character codes, parser phases, outcome codes and the beat formats that
// pass between the front end, the queues and the parser.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HI = 8'h66;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        PH_SIZE = 2'd0,
        PH_DATA = 2'd1,
        PH_TAIL = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        OUT_RUN   = 2'd0,
        OUT_OK    = 2'd1,
        OUT_EMPTY = 2'd2,
        OUT_BAD   = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_lf;
        logic       is_cr;
        logic       is_blank;
        logic       first;
        logic       last;
    } t_cls;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       body_end;
        t_outcome   outcome;
    } t_res;

endpackage

### design/cbd_fifo.sv
// ----------------------------------------------------------------------------
// cbd_fifo: short register queue
// Holds up to DEPTH beats; the oldest beat is shown while the queue is not
// empty. A push is taken only when the queue is not full.
// ----------------------------------------------------------------------------
module cbd_fifo
    import cbd_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### design/cbd_front.sv
// ----------------------------------------------------------------------------
// cbd_front: byte classifier
// Accepts input beats and tags each byte as hex digit, line feed, carriage
// return or whitespace before it enters the work queue.
// ----------------------------------------------------------------------------
module cbd_front
    import cbd_pkg::*;
(
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_first,
    input  logic       i_last,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cls       o_item
);

    logic is_digit, is_upper, is_lower;

    assign is_digit = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_NINE);
    assign is_upper = (i_in_byte >= CH_UA) && (i_in_byte <= CH_UF);
    assign is_lower = (i_in_byte >= CH_LA) && (i_in_byte <= CH_LF_HI);

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_item.in_byte  = i_in_byte;
        o_item.is_hex   = is_digit || is_upper || is_lower;
        o_item.hex_val  = is_digit ? i_in_byte[3:0] : 4'(i_in_byte[3:0] + 4'd9);
        o_item.is_lf    = (i_in_byte == CH_LF);
        o_item.is_cr    = (i_in_byte == CH_CR);
        o_item.is_blank = (i_in_byte == CH_SPACE) || (i_in_byte == CH_TAB)
                       || (i_in_byte == CH_CR) || (i_in_byte == CH_VT)
                       || (i_in_byte == CH_FF);
        o_item.first    = i_first;
        o_item.last     = i_last;
    end

endmodule

### design/cbd_back.sv
// ----------------------------------------------------------------------------
// cbd_back: chunk parser
// Takes classified beats from the work queue, tracks the size line, data
// and line tail phases, and pushes one result beat per byte.
// ----------------------------------------------------------------------------
module cbd_back
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cls i_item,
    input  logic i_q_empty,
    output logic o_q_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_bytes_left, n_bytes_left;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_digits_closed, n_digits_closed;
    logic                 r_payload_seen, n_payload_seen;
    logic                 take, ended, skip;
    t_outcome             code;

    assign take       = !i_q_empty && !i_res_full;
    assign o_q_pop    = take;
    assign o_res_push = take;

    always_comb begin
        n_phase         = r_phase;
        n_bytes_left    = r_bytes_left;
        n_digit_seen    = r_digit_seen;
        n_digits_closed = r_digits_closed;
        n_payload_seen  = r_payload_seen;
        ended           = 1'b0;
        skip            = 1'b0;
        code            = OUT_RUN;
        o_res           = '0;
        if (i_item.first) begin
            n_phase         = PH_SIZE;
            n_bytes_left    = '0;
            n_digit_seen    = 1'b0;
            n_digits_closed = 1'b0;
            n_payload_seen  = 1'b0;
        end
        unique case (n_phase)
            PH_DONE: begin
                skip = 1'b1;
            end
            PH_SIZE: begin
                if (i_item.is_lf) begin
                    if (n_digit_seen) begin
                        if (n_bytes_left == '0) begin
                            ended = 1'b1;
                            code  = n_payload_seen ? OUT_OK : OUT_EMPTY;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                    n_digit_seen    = 1'b0;
                    n_digits_closed = 1'b0;
                end else if (n_digit_seen && n_digits_closed) begin
                    ended = 1'b1;
                    code  = OUT_BAD;
                end else if (i_item.is_hex) begin
                    if (n_digits_closed || (n_bytes_left[SIZE_BITS-1 -: 4] != 4'd0)) begin
                        ended = 1'b1;
                        code  = OUT_BAD;
                    end else begin
                        n_bytes_left = {n_bytes_left[SIZE_BITS-5:0], i_item.hex_val};
                        n_digit_seen = 1'b1;
                    end
                end else if (n_digit_seen) begin
                    if (i_item.is_cr) begin
                        n_digits_closed = 1'b1;
                    end else begin
                        ended = 1'b1;
                        code  = OUT_BAD;
                    end
                end else if (i_item.is_blank) begin
                    n_digits_closed = 1'b1;
                end else begin
                    ended = 1'b1;
                    code  = OUT_BAD;
                end
            end
            PH_DATA: begin
                o_res.data_byte  = i_item.in_byte;
                o_res.data_valid = 1'b1;
                n_payload_seen   = 1'b1;
                n_bytes_left     = n_bytes_left - SIZE_BITS'(1);
                if (n_bytes_left == '0) begin
                    n_phase = PH_TAIL;
                end
            end
            PH_TAIL: begin
                if (i_item.is_lf) begin
                    n_phase         = PH_SIZE;
                    n_bytes_left    = '0;
                    n_digit_seen    = 1'b0;
                    n_digits_closed = 1'b0;
                end
            end
            default: begin
                skip = 1'b1;
            end
        endcase
        if (!skip) begin
            if (!ended && i_item.last) begin
                ended = 1'b1;
                code  = n_payload_seen ? OUT_OK : OUT_EMPTY;
            end
            if (ended) begin
                n_phase = PH_DONE;
            end
            o_res.body_end = ended;
            o_res.outcome  = code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SIZE;
            r_bytes_left    <= '0;
            r_digit_seen    <= 1'b0;
            r_digits_closed <= 1'b0;
            r_payload_seen  <= 1'b0;
        end else if (take) begin
            r_phase         <= n_phase;
            r_bytes_left    <= n_bytes_left;
            r_digit_seen    <= n_digit_seen;
            r_digits_closed <= n_digits_closed;
            r_payload_seen  <= n_payload_seen;
        end
    end

endmodule

### design/chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// chunked_body_decoder: HTTP chunked transfer body decoder
// A byte goes through the work queue and the parser into the result queue.
// Throughput: one byte per cycle while neither queue stalls.
// Each queue holds QUEUE_DEPTH beats, so either side may stall on its own.
// Reset is synchronous and active low; it empties both queues and returns
// the parser to the size line phase.
// ----------------------------------------------------------------------------
module chunked_body_decoder
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS   = 24,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_first,
    input  logic       i_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic       o_body_end,
    output logic [1:0] o_outcome
);

    t_cls front_item, back_item;
    t_res back_res, head_res;
    logic q_push, q_empty, q_pop;
    logic res_full, res_push;

    cbd_front u_front (
        .i_push    (push),
        .i_in_byte (i_in_byte),
        .i_first   (i_first),
        .i_last    (i_last),
        .i_q_full  (full),
        .o_q_push  (q_push),
        .o_item    (front_item)
    );

    cbd_fifo #(
        .WIDTH ($bits(t_cls)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (back_item),
        .o_empty (q_empty)
    );

    cbd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (back_item),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (back_res)
    );

    cbd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (head_res),
        .o_empty (empty)
    );

    assign o_data_byte  = head_res.data_byte;
    assign o_data_valid = head_res.data_valid;
    assign o_body_end   = head_res.body_end;
    assign o_outcome    = head_res.outcome;

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the chunked body decoder
// A short table of hand-written bodies comes first, then randomly built
// chunked bodies, most of them well formed, some cut short, corrupted or
// mixed with noise. Every accepted result beat is checked field by field against
// the table's expected result or an in-bench model of the parser. Both sides idle
// at random, and the receiver once holds off long enough for the input side to stall.
// ----------------------------------------------------------------------------
module tb_top;
    import cbd_pkg::*;

    localparam int SIZE_BITS   = 24;
    localparam int N_RANDOM    = 1050;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] val;
        logic       b_first;
        logic       b_last;
    } t_beat;

    typedef struct packed {
        t_beat beat;
        logic  known;
        t_res  want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_first = 1'b0;
    logic       i_last = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_body_end;
    logic [1:0] o_outcome;

    t_phase                 pr_phase = PH_SIZE;
    logic [SIZE_BITS-1:0]   pr_left = '0;
    logic                   pr_digit = 1'b0;
    logic                   pr_closed = 1'b0;
    logic                   pr_payload = 1'b0;

    t_res       pending_res[$];
    t_row       dir_rows[$];
    t_beat      stim[$];
    logic [7:0] body_buf[$];
    int         n_mismatch = 0;
    int         n_popped = 0;
    int         idle_cycles = 0;
    t_res       want_res;
    t_res       got_res;

    chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_byte    (i_in_byte),
        .i_first      (i_first),
        .i_last       (i_last),
        .empty        (empty),
        .pop          (pop),
        .o_data_byte  (o_data_byte),
        .o_data_valid (o_data_valid),
        .o_body_end   (o_body_end),
        .o_outcome    (o_outcome)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_res decode_byte(logic [7:0] c, logic f, logic l);
        t_res       r;
        logic       ended;
        logic       is_hex;
        logic [3:0] hv;
        logic       blank;
        r = '0;
        r.outcome = OUT_RUN;
        ended = 1'b0;
        if (f) begin
            pr_phase = PH_SIZE;
            pr_left = '0;
            pr_digit = 1'b0;
            pr_closed = 1'b0;
            pr_payload = 1'b0;
        end
        if (pr_phase == PH_DONE) begin
            return r;
        end
        is_hex = 1'b1;
        hv = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            hv = 4'(c - CH_ZERO);
        end else if (c >= CH_UA && c <= CH_UF) begin
            hv = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF_HI) begin
            hv = 4'(c - CH_LA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
                (c == CH_VT) || (c == CH_FF);
        case (pr_phase)
            PH_SIZE: begin
                if (c == CH_LF) begin
                    if (pr_digit) begin
                        if (pr_left == '0) begin
                            ended = 1'b1;
                            r.outcome = pr_payload ? OUT_OK : OUT_EMPTY;
                        end else begin
                            pr_phase = PH_DATA;
                        end
                    end
                    pr_digit = 1'b0;
                    pr_closed = 1'b0;
                end else if (pr_digit && pr_closed) begin
                    ended = 1'b1;
                    r.outcome = OUT_BAD;
                end else if (is_hex) begin
                    if (pr_closed || pr_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                        ended = 1'b1;
                        r.outcome = OUT_BAD;
                    end else begin
                        pr_left = {pr_left[SIZE_BITS-5:0], hv};
                        pr_digit = 1'b1;
                    end
                end else if (pr_digit) begin
                    if (c == CH_CR) begin
                        pr_closed = 1'b1;
                    end else begin
                        ended = 1'b1;
                        r.outcome = OUT_BAD;
                    end
                end else if (blank) begin
                    pr_closed = 1'b1;
                end else begin
                    ended = 1'b1;
                    r.outcome = OUT_BAD;
                end
            end
            PH_DATA: begin
                r.data_byte = c;
                r.data_valid = 1'b1;
                pr_payload = 1'b1;
                pr_left = pr_left - 1'b1;
                if (pr_left == '0) begin
                    pr_phase = PH_TAIL;
                end
            end
            default: begin
                if (c == CH_LF) begin
                    pr_phase = PH_SIZE;
                    pr_left = '0;
                    pr_digit = 1'b0;
                    pr_closed = 1'b0;
                end
            end
        endcase
        if (!ended && l) begin
            ended = 1'b1;
            r.outcome = pr_payload ? OUT_OK : OUT_EMPTY;
        end
        if (ended) begin
            pr_phase = PH_DONE;
        end
        r.body_end = ended;
        return r;
    endfunction

    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + 8'(v);
        end
        if ($urandom_range(0, 1) == 1) begin
            return CH_UA + 8'(v) - 8'd10;
        end
        return CH_LA + 8'(v) - 8'd10;
    endfunction

    task automatic put_hex(input int unsigned val, input int ndig);
        int i;
        for (i = ndig - 1; i >= 0; i--) begin
            body_buf.push_back(hex_char(4'(val >> (4 * i))));
        end
    endtask

    task automatic put_blank();
        case ($urandom_range(0, 4))
            0: body_buf.push_back(CH_SPACE);
            1: body_buf.push_back(CH_TAB);
            2: body_buf.push_back(CH_CR);
            3: body_buf.push_back(CH_VT);
            default: body_buf.push_back(CH_FF);
        endcase
    endtask

    task automatic gen_body();
        int    kind;
        int    sz;
        int    nd;
        int    cut;
        int    i;
        bit    mark_last;
        t_beat b;
        body_buf.delete();
        kind = $urandom_range(0, 39);
        mark_last = ($urandom_range(0, 1) == 1);
        if (kind == 0) begin
            body_buf.push_back(hex_char(4'($urandom_range(1, 15))));
            put_hex($urandom, 6);
            body_buf.push_back(CH_LF);
        end else if (kind == 1) begin
            put_hex($urandom_range(24'h100000, 24'hFFFFFF), 6);
            if ($urandom_range(0, 1) == 1) begin
                body_buf.push_back(CH_CR);
            end
            body_buf.push_back(CH_LF);
            repeat ($urandom_range(1, 6)) body_buf.push_back(8'($urandom_range(0, 255)));
            mark_last = 1'b1;
        end else begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(0, 2)) put_blank();
                    body_buf.push_back(CH_LF);
                end
                sz = ($urandom_range(0, 14) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
                nd = (sz > 15) ? 2 : 1;
                if ($urandom_range(0, 3) == 0) begin
                    nd++;
                end
                put_hex(sz, nd);
                if ($urandom_range(0, 3) != 0) begin
                    body_buf.push_back(CH_CR);
                end
                body_buf.push_back(CH_LF);
                repeat (sz) body_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) == 0) begin
                    body_buf.push_back(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 3) != 0) begin
                    body_buf.push_back(CH_CR);
                end
                body_buf.push_back(CH_LF);
            end
            put_hex(0, $urandom_range(1, 2));
            if ($urandom_range(0, 1) == 1) begin
                body_buf.push_back(CH_CR);
            end
            body_buf.push_back(CH_LF);
            if ($urandom_range(0, 5) == 0) begin
                body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
        cut = body_buf.size();
        if (kind > 1 && $urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, body_buf.size());
            mark_last = 1'b1;
        end
        for (i = 0; i < cut; i++) begin
            b.val = body_buf[i];
            b.b_first = (i == 0);
            b.b_last = (i == cut - 1) && mark_last;
            stim.push_back(b);
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                b.val = 8'($urandom_range(0, 255));
                b.b_first = ($urandom_range(0, 3) == 0);
                b.b_last = ($urandom_range(0, 3) == 0);
                stim.push_back(b);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] v, input logic f, input logic l, input logic known,
                           input logic [7:0] db, input logic dv, input logic be,
                           input t_outcome oc);
        t_row r;
        r.beat.val = v;
        r.beat.b_first = f;
        r.beat.b_last = l;
        r.known = known;
        r.want.data_byte = db;
        r.want.data_valid = dv;
        r.want.body_end = be;
        r.want.outcome = oc;
        dir_rows.push_back(r);
    endtask

    task automatic send_beat(input t_beat b, input logic known, input t_res want, input int gap);
        t_res r;
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_in_byte <= b.val;
        i_first <= b.b_first;
        i_last <= b.b_last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        r = decode_byte(b.val, b.b_first, b.b_last);
        pending_res.push_back(known ? want : r);
    endtask

    task automatic report(input string what, input t_res want, input t_res got);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("%s: expected byte=%02h valid=%0d end=%0d outcome=%0d, got byte=%02h valid=%0d end=%0d outcome=%0d",
                     what, want.data_byte, want.data_valid, want.body_end, want.outcome,
                     got.data_byte, got.data_valid, got.body_end, got.outcome);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (pop && !empty) begin
                n_popped <= n_popped + 1;
                got_res.data_byte = o_data_byte;
                got_res.data_valid = o_data_valid;
                got_res.body_end = o_body_end;
                got_res.outcome = t_outcome'(o_outcome);
                if (pending_res.size() == 0) begin
                    report("unexpected beat", '0, got_res);
                end else begin
                    want_res = pending_res.pop_front();
                    if (got_res.data_byte !== want_res.data_byte ||
                        got_res.data_valid !== want_res.data_valid ||
                        got_res.body_end !== want_res.body_end ||
                        got_res.outcome !== want_res.outcome) begin
                        report("mismatch", want_res, got_res);
                    end
                end
            end
        end
    end

    initial begin : drain
        int stall_left;
        int rx_cycle;
        bit held;
        stall_left = 0;
        rx_cycle = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (!held && n_popped >= 400) begin
                stall_left = HOLD_CYCLES;
                held = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                stall_left = gap_len(((rx_cycle / 150) % 4) == 1);
            end
        end
    end

    initial begin : feed
        int i;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(CH_ZERO,  1, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_LF,    0, 0, 1, 8'h00, 0, 1, OUT_EMPTY);
        add_row("x",      0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_SPACE, 1, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_LF,    0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row("2",      0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_CR,    0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_LF,    0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(8'hFF,    0, 0, 1, 8'hFF, 1, 0, OUT_RUN);
        add_row(8'h00,    0, 0, 1, 8'h00, 1, 0, OUT_RUN);
        add_row(CH_LF,    0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_ZERO,  0, 0, 1, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_LF,    0, 0, 1, 8'h00, 0, 1, OUT_OK);
        add_row("g",      1, 0, 1, 8'h00, 0, 1, OUT_BAD);
        add_row(CH_SPACE, 1, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("5",      0, 0, 1, 8'h00, 0, 1, OUT_BAD);
        add_row("1",      1, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_CR,    0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("x",      0, 0, 1, 8'h00, 0, 1, OUT_BAD);
        add_row("F",      1, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("f",      0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("a",      0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("A",      0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("9",      0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row(CH_ZERO,  0, 0, 0, 8'h00, 0, 0, OUT_RUN);
        add_row("F",      0, 0, 1, 8'h00, 0, 1, OUT_BAD);
        add_row(CH_SPACE, 1, 1, 1, 8'h00, 0, 1, OUT_EMPTY);

        for (i = 0; i < dir_rows.size(); i++) begin
            send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want, gap_len(1'b0));
        end

        while (stim.size() < N_RANDOM) gen_body();
        for (i = 0; i < stim.size(); i++) begin
            send_beat(stim[i], 1'b0, '0, gap_len(((i / 80) % 4) == 3));
        end
        @(negedge i_clk);
        push <= 1'b0;

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_mismatch == 0 && pending_res.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
